FILE: sv/bpp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the duty table for the buzzer pattern player.
// No dependencies; imported by every module of the block.
package bpp_pkg;

  typedef enum logic [1:0] {
    CMD_FAST_TICK    = 2'd0,
    CMD_PATTERN_TICK = 2'd1,
    CMD_START        = 2'd2,
    CMD_STOP         = 2'd3
  } cmd_t;

  localparam logic [2:0] PAT_CHARGE = 3'd0;
  localparam logic [2:0] PAT_ALARM1 = 3'd1;
  localparam logic [2:0] PAT_ALARM2 = 3'd2;
  localparam logic [2:0] PAT_ALARM3 = 3'd3;
  localparam logic [2:0] PAT_HOUR   = 3'd4;

  localparam logic [1:0] REG_PWM_PERIOD      = 2'd0;
  localparam logic [1:0] REG_ALARM_ROUNDS    = 2'd1;
  localparam logic [1:0] REG_STOP_MIN_ROUNDS = 2'd2;

  localparam logic [5:0] PWM_PERIOD_RST      = 6'd25;
  localparam logic [3:0] ALARM_ROUNDS_RST    = 4'd5;
  localparam logic [3:0] STOP_MIN_ROUNDS_RST = 4'd2;

  localparam logic [10:0] CHARGE_END    = 11'd240;
  localparam logic [10:0] HOUR_END      = 11'd100;
  localparam logic [10:0] ALARM_PERIOD  = 11'd800;
  localparam logic [10:0] ALARM3_PERIOD = 11'd1200;
  localparam logic [12:0] PERCENT_SCALE = 13'd100;

  localparam logic [6:0] DUTY_OFF  = 7'd0;
  localparam logic [6:0] DUTY_LOW  = 7'd25;
  localparam logic [6:0] DUTY_MID  = 7'd40;
  localparam logic [6:0] DUTY_HIGH = 7'd60;
  localparam logic [6:0] DUTY_MAX  = 7'd95;

  typedef struct packed {
    logic buzzer_level;
    logic playing;
    logic finished;
  } res_t;

  function automatic logic in_window(input logic [10:0] s, input logic [10:0] lo,
                                     input logic [10:0] hi);
    in_window = (s > lo) && (s < hi);
  endfunction

  // Duty in percent for a pattern at a given step; windows are open intervals.
  function automatic logic [6:0] pick_duty(input logic [2:0] p, input logic [10:0] s);
    logic is_alarm23;
    is_alarm23 = (p == PAT_ALARM2) || (p == PAT_ALARM3);
    pick_duty  = DUTY_OFF;
    if (in_window(s, 11'd0, 11'd100)) begin
      pick_duty = DUTY_LOW;
    end else if (p == PAT_CHARGE) begin
      if (in_window(s, 11'd160, 11'd240)) pick_duty = DUTY_MID;
    end else if (p == PAT_ALARM1) begin
      if (in_window(s, 11'd200, 11'd500)) pick_duty = DUTY_MAX;
    end else if (is_alarm23) begin
      if (in_window(s, 11'd200, 11'd300)) begin
        pick_duty = DUTY_MID;
      end else if (in_window(s, 11'd400, 11'd500)) begin
        pick_duty = DUTY_LOW;
      end else if ((p == PAT_ALARM3) && in_window(s, 11'd600, 11'd700)) begin
        pick_duty = DUTY_HIGH;
      end
    end
  endfunction

endpackage

FILE: sv/bpp_core.sv
`timescale 1ns / 1ps
// Pattern sequencer, PWM phase counter and configuration registers.
// Depends on bpp_pkg; computes one result per transfer from the current state.
module bpp_core import bpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [1:0] command,
  input  logic [2:0] pattern,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata,
  output res_t       res
);

  logic [5:0]  pwm_period_r;
  logic [3:0]  alarm_rounds_r;
  logic [3:0]  stop_min_rounds_r;

  logic [5:0]  pwm_phase_r, pwm_phase_nxt;
  logic [10:0] step_count_r, step_count_nxt;
  logic [3:0]  rounds_done_r, rounds_done_nxt;
  logic [2:0]  cur_pattern_r, cur_pattern_nxt;
  logic        active_r, active_nxt;
  logic        stop_pending_r, stop_pending_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic        pin_r, pin_nxt;
  logic        finished;

  logic [6:0]  phase_inc;
  logic [12:0] duty_prod;
  logic [12:0] phase_scaled;
  logic [10:0] step_inc;
  logic [10:0] alarm_len;
  logic [3:0]  rounds_inc;
  logic        is_alarm;

  always_comb begin
    phase_inc    = {1'b0, pwm_phase_r} + 7'd1;
    // next phase < floor(duty * period / 100) is the same as 100 * (next phase + 1) <= duty * period.
    duty_prod    = {6'd0, duty_r} * {7'd0, pwm_period_r};
    phase_scaled = ({6'd0, phase_inc} + 13'd1) * PERCENT_SCALE;
    step_inc     = step_count_r + 11'd1;
    alarm_len    = (cur_pattern_r == PAT_ALARM3) ? ALARM3_PERIOD : ALARM_PERIOD;
    is_alarm     = (cur_pattern_r == PAT_ALARM1) || (cur_pattern_r == PAT_ALARM2) ||
                   (cur_pattern_r == PAT_ALARM3);
    rounds_inc   = rounds_done_r + 4'd1;
  end

  always_comb begin
    pwm_phase_nxt    = pwm_phase_r;
    step_count_nxt   = step_count_r;
    rounds_done_nxt  = rounds_done_r;
    cur_pattern_nxt  = cur_pattern_r;
    active_nxt       = active_r;
    stop_pending_nxt = stop_pending_r;
    duty_nxt         = duty_r;
    pin_nxt          = pin_r;
    finished         = 1'b0;
    case (cmd_t'(command))
      CMD_FAST_TICK: begin
        if (active_r) begin
          pin_nxt = phase_scaled <= duty_prod;
          if (phase_inc >= {1'b0, pwm_period_r}) begin
            pwm_phase_nxt = 6'd0;
          end else begin
            pwm_phase_nxt = phase_inc[5:0];
          end
        end
      end
      CMD_PATTERN_TICK: begin
        if (active_r) begin
          step_count_nxt = step_inc;
          duty_nxt       = pick_duty(cur_pattern_r, step_inc);
          if (!is_alarm) begin
            finished = (cur_pattern_r == PAT_CHARGE) ? (step_inc >= CHARGE_END)
                                                     : (step_inc >= HOUR_END);
          end else begin
            if (step_inc >= alarm_len) begin
              step_count_nxt  = 11'd0;
              rounds_done_nxt = rounds_inc;
            end
            finished = (rounds_done_nxt == alarm_rounds_r) ||
                       (stop_pending_r && (rounds_done_nxt > stop_min_rounds_r));
          end
          if (finished) begin
            active_nxt       = 1'b0;
            stop_pending_nxt = 1'b0;
            duty_nxt         = DUTY_OFF;
            step_count_nxt   = 11'd0;
            rounds_done_nxt  = 4'd0;
            pin_nxt          = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (pattern <= PAT_HOUR) begin
          cur_pattern_nxt  = pattern;
          active_nxt       = 1'b1;
          stop_pending_nxt = 1'b0;
          duty_nxt         = DUTY_OFF;
          step_count_nxt   = 11'd0;
          rounds_done_nxt  = 4'd0;
          pin_nxt          = 1'b0;
        end
      end
      CMD_STOP: begin
        if (active_r && is_alarm) stop_pending_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.buzzer_level = active_nxt && pin_nxt;
    res.playing      = active_nxt;
    res.finished     = finished;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r      <= PWM_PERIOD_RST;
      alarm_rounds_r    <= ALARM_ROUNDS_RST;
      stop_min_rounds_r <= STOP_MIN_ROUNDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PWM_PERIOD:      pwm_period_r      <= cfg_wdata;
        REG_ALARM_ROUNDS:    alarm_rounds_r    <= cfg_wdata[3:0];
        REG_STOP_MIN_ROUNDS: stop_min_rounds_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_phase_r    <= 6'd0;
      step_count_r   <= 11'd0;
      rounds_done_r  <= 4'd0;
      cur_pattern_r  <= PAT_CHARGE;
      active_r       <= 1'b0;
      stop_pending_r <= 1'b0;
      duty_r         <= DUTY_OFF;
      pin_r          <= 1'b0;
    end else if (take) begin
      pwm_phase_r    <= pwm_phase_nxt;
      step_count_r   <= step_count_nxt;
      rounds_done_r  <= rounds_done_nxt;
      cur_pattern_r  <= cur_pattern_nxt;
      active_r       <= active_nxt;
      stop_pending_r <= stop_pending_nxt;
      duty_r         <= duty_nxt;
      pin_r          <= pin_nxt;
    end
  end

endmodule

FILE: sv/bpp_out_buf.sv
`timescale 1ns / 1ps
// Two-entry result buffer: an output register and a skid register.
// Depends on bpp_pkg for the result type.
module bpp_out_buf import bpp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop || !out_valid_r) begin
      // The skid entry is older than any new transfer, so it drains first.
      out_nxt        = skid_valid_r ? skid_r : push_data;
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/buzzer_pattern_player.sv
`timescale 1ns / 1ps
// Buzzer pattern player: one command per transfer in, one pin/status result out.
// Depends on bpp_pkg, bpp_core and bpp_out_buf.
//
// The block takes one command in every clock cycle while in_stall is low, and
// its result is registered into the output buffer; the pattern state and the PWM
// phase are updated at the same clock edge, so commands may follow one another with no gap. A
// two-entry output buffer holds results while out_stall is high, and in_stall
// rises only once both entries are full. Configuration takes effect on the
// next command; write it while no result is outstanding.
module buzzer_pattern_player import bpp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [2:0] in_pattern,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_buzzer_level,
  output logic       out_playing,
  output logic       out_finished,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  logic take;
  logic buf_full;
  res_t core_res;
  res_t out_res;

  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  bpp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .command   (in_command),
    .pattern   (in_pattern),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (core_res)
  );

  bpp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_buzzer_level = out_res.buzzer_level;
  assign out_playing      = out_res.playing;
  assign out_finished     = out_res.finished;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for buzzer_pattern_player: a queued command driver, a result monitor
// and a command-level predictor of the pin and status. Depends on bpp_pkg and the block's RTL.
module tb;
  import bpp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0] command;
    logic [2:0] pattern;
  } cmd_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_FAST_TICK;
  logic [2:0] in_pattern = PAT_CHARGE;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_buzzer_level;
  logic       out_playing;
  logic       out_finished;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_PWM_PERIOD;
  logic [5:0] cfg_wdata = '0;

  cmd_item_t pending_cmds[$];
  cmd_item_t next_cmd;
  res_t      due_results[$];

  // Register copies and player state as the predictor sees them.
  logic [5:0]  cfg_period;
  logic [3:0]  cfg_rounds;
  logic [3:0]  cfg_stop_min;
  logic [5:0]  pl_phase;
  logic [10:0] pl_step;
  logic [3:0]  pl_rounds;
  logic [2:0]  pl_pattern;
  logic        pl_active;
  logic        pl_stop_req;
  logic [6:0]  pl_duty;
  logic        pl_pin;

  bit gaps_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int fail_count = 0;
  int commands_accepted = 0;
  int patterns_finished = 0;
  int settings_used = 0;
  int cycle_count = 0;

  buzzer_pattern_player u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_pattern       (in_pattern),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_buzzer_level (out_buzzer_level),
    .out_playing      (out_playing),
    .out_finished     (out_finished),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] rnd_pat();
    return 3'($urandom_range(7));
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(20, 6);
  endfunction

  function automatic logic [6:0] duty_for(input logic [2:0] pat, input logic [10:0] s);
    if (s > 0 && s < 100) return DUTY_LOW;
    case (pat)
      PAT_CHARGE: begin
        if (s > 160 && s < 240) return DUTY_MID;
      end
      PAT_ALARM1: begin
        if (s > 200 && s < 500) return DUTY_MAX;
      end
      PAT_ALARM2, PAT_ALARM3: begin
        if (s > 200 && s < 300) return DUTY_MID;
        if (s > 400 && s < 500) return DUTY_LOW;
        if (pat == PAT_ALARM3 && s > 600 && s < 700) return DUTY_HIGH;
      end
      default: ;
    endcase
    return DUTY_OFF;
  endfunction

  task automatic silence_player();
    pl_active   = 1'b0;
    pl_stop_req = 1'b0;
    pl_duty     = DUTY_OFF;
    pl_step     = '0;
    pl_rounds   = '0;
    pl_pin      = 1'b0;
  endtask

  // Works out the pin and status that one accepted command leaves behind.
  task automatic play_command(input logic [1:0] cmd, input logic [2:0] pat);
    res_t r;
    logic done;
    int   next_phase;
    int   threshold;
    done = 1'b0;
    case (cmd)
      CMD_FAST_TICK: begin
        if (pl_active) begin
          next_phase = int'(pl_phase) + 1;
          threshold  = int'(pl_duty) * int'(cfg_period) / 100;
          pl_pin     = next_phase < threshold;
          if (next_phase >= int'(cfg_period)) next_phase = 0;
          pl_phase = next_phase[5:0];
        end
      end
      CMD_PATTERN_TICK: begin
        if (pl_active) begin
          pl_step = pl_step + 11'd1;
          pl_duty = duty_for(pl_pattern, pl_step);
          if (pl_pattern == PAT_CHARGE || pl_pattern == PAT_HOUR) begin
            done = pl_step >= ((pl_pattern == PAT_CHARGE) ? CHARGE_END : HOUR_END);
          end else begin
            if (pl_step >= ((pl_pattern == PAT_ALARM3) ? ALARM3_PERIOD : ALARM_PERIOD)) begin
              pl_step   = '0;
              pl_rounds = pl_rounds + 4'd1;
            end
            done = (pl_rounds == cfg_rounds) || (pl_stop_req && pl_rounds > cfg_stop_min);
          end
          if (done) silence_player();
        end
      end
      CMD_START: begin
        if (pat <= PAT_HOUR) begin
          silence_player();
          pl_pattern = pat;
          pl_active  = 1'b1;
        end
      end
      CMD_STOP: begin
        // Only the alarms take notice of a stop request.
        if (pl_active && pl_pattern != PAT_CHARGE && pl_pattern != PAT_HOUR) pl_stop_req = 1'b1;
      end
      default: ;
    endcase
    r.buzzer_level = pl_active & pl_pin;
    r.playing      = pl_active;
    r.finished     = done;
    due_results.push_back(r);
  endtask

  task automatic check_result();
    res_t want;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: level %0b playing %0b finished %0b",
                 out_buzzer_level, out_playing, out_finished);
    end else begin
      want = due_results.pop_front();
      if (want.finished) patterns_finished++;
      if (out_buzzer_level !== want.buzzer_level || out_playing !== want.playing ||
          out_finished !== want.finished) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch at %0t: level %0b/%0b playing %0b/%0b finished %0b/%0b (exp/got)",
                   $realtime, want.buzzer_level, out_buzzer_level, want.playing, out_playing,
                   want.finished, out_finished);
      end
    end
  endtask

  // Driver: the payload holds while stalled and the next command follows a random gap while gaps are on.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        play_command(in_command, in_pattern);
        commands_accepted++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd = pending_cmds.pop_front();
        in_command <= next_cmd.command;
        in_pattern <= next_cmd.pattern;
        in_valid   <= 1'b1;
        send_gap = gaps_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every result transfer and, while gaps are on, throws in stalls of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (stall_left == 0 && gaps_on && $urandom_range(3) == 0) stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_cmd(input logic [1:0] cmd, input logic [2:0] pat);
    cmd_item_t c;
    c.command = cmd;
    c.pattern = pat;
    pending_cmds.push_back(c);
  endtask

  // Holds off until every queued command has been answered, then lets the block settle.
  task automatic wait_drained();
    do @(negedge clk); while (pending_cmds.size() != 0 || in_valid || due_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PWM_PERIOD:      cfg_period   = val;
      REG_ALARM_ROUNDS:    cfg_rounds   = val[3:0];
      REG_STOP_MIN_ROUNDS: cfg_stop_min = val[3:0];
      default: ;
    endcase
  endtask

  // One pattern run: a start, then pattern ticks mixed with fast ticks, bursts, an optional stop and the odd stray.
  task automatic queue_session(input logic [2:0] pat, input int ticks, input int fast_pct,
                               input bit with_stop);
    int n;
    int k;
    int burst;
    int stop_at;
    stop_at = with_stop ? int'($urandom_range(ticks)) : -1;
    push_cmd(CMD_START, pat);
    for (n = 0; n < ticks; n++) begin
      if (n == stop_at) push_cmd(CMD_STOP, rnd_pat());
      push_cmd(CMD_PATTERN_TICK, rnd_pat());
      if ($urandom_range(99) < fast_pct) push_cmd(CMD_FAST_TICK, rnd_pat());
      if ($urandom_range(99) < 1) begin
        burst = $urandom_range(20, 1);
        for (k = 0; k < burst; k++) push_cmd(CMD_FAST_TICK, rnd_pat());
      end
      if ($urandom_range(199) == 0) push_cmd(2'($urandom_range(3)), rnd_pat());
    end
  endtask

  task automatic queue_random_session();
    logic [2:0] pat;
    int         ticks;
    pat = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    ticks = $urandom_range(20, 1);
    queue_session(pat, ticks, 40, $urandom_range(3) == 0);
  endtask

  task automatic run_phase(input logic [5:0] period, input logic [3:0] rounds,
                           input logic [3:0] stop_min, input logic [2:0] long_pat,
                           input int long_ticks, input bit long_stop);
    logic [1:0] spare_a;
    logic [1:0] spare_b;
    spare_a = 2'($urandom_range(3));
    spare_b = 2'($urandom_range(3));
    wait_drained();
    write_reg(REG_PWM_PERIOD, period);
    write_reg(REG_ALARM_ROUNDS, {spare_a, rounds});
    write_reg(REG_STOP_MIN_ROUNDS, {spare_b, stop_min});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
    gaps_on = ($urandom_range(2) != 0);
    queue_random_session();
    // The sender holds here until every result of the short run is in.
    wait_drained();
    queue_session(long_pat, long_ticks, 20, long_stop);
  endtask

  initial begin
    cfg_period   = PWM_PERIOD_RST;
    cfg_rounds   = ALARM_ROUNDS_RST;
    cfg_stop_min = STOP_MIN_ROUNDS_RST;
    pl_phase     = '0;
    pl_pattern   = PAT_CHARGE;
    silence_player();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening on the reset settings: idle ticks, ignored starts and stops,
    // fast ticks at the lowest duty, and restarts of a running pattern.
    push_cmd(CMD_FAST_TICK, rnd_pat());
    push_cmd(CMD_PATTERN_TICK, rnd_pat());
    push_cmd(CMD_STOP, rnd_pat());
    push_cmd(CMD_START, 3'd5);
    push_cmd(CMD_START, 3'd7);
    push_cmd(CMD_START, PAT_HOUR);
    push_cmd(CMD_STOP, rnd_pat());
    push_cmd(CMD_PATTERN_TICK, rnd_pat());
    repeat (7) push_cmd(CMD_FAST_TICK, rnd_pat());
    push_cmd(CMD_START, PAT_ALARM1);
    push_cmd(CMD_STOP, 3'd6);
    push_cmd(CMD_PATTERN_TICK, rnd_pat());
    push_cmd(CMD_FAST_TICK, rnd_pat());
    push_cmd(CMD_START, PAT_CHARGE);
    push_cmd(CMD_PATTERN_TICK, rnd_pat());
    push_cmd(CMD_FAST_TICK, rnd_pat());
    push_cmd(CMD_START, PAT_ALARM2);
    push_cmd(CMD_START, PAT_ALARM3);
    push_cmd(CMD_PATTERN_TICK, rnd_pat());
    push_cmd(CMD_FAST_TICK, rnd_pat());

    run_phase(6'd1, 4'd1, 4'd0, PAT_ALARM1, 12, 1'b0);
    run_phase(6'd63, 4'd15, 4'd15, PAT_CHARGE, 245, 1'b1);
    run_phase(6'd0, 4'd3, 4'd0, PAT_ALARM2, 12, 1'b1);
    run_phase(6'($urandom_range(63)), 4'($urandom_range(15)), 4'($urandom_range(15)),
              PAT_HOUR, 105, 1'b1);
    run_phase(PWM_PERIOD_RST, ALARM_ROUNDS_RST, STOP_MIN_ROUNDS_RST, PAT_ALARM3, 12, 1'b1);

    wait_drained();
    fail_count += due_results.size();
    $display("%0d commands checked over %0d register settings plus reset values;",
             commands_accepted, settings_used);
    $display("%0d patterns ran to their end, %0d failures", patterns_finished, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: buzzer_pattern_player.f
sv/bpp_pkg.sv
sv/bpp_core.sv
sv/bpp_out_buf.sv
sv/buzzer_pattern_player.sv
bench/tb.sv
